### rtl/two_key_mapping_table_assert.svh
// assertion macros for the mapping table
`ifndef TWO_KEY_MAPPING_TABLE_ASSERT_SVH
`define TWO_KEY_MAPPING_TABLE_ASSERT_SVH
`ifndef SYNTH
`define TKM_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define TKM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TKM_ASSERT_SAME(lbl, ante, cons, msg)
`define TKM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

### rtl/tkm_pkg.sv
// types and codes shared by the mapping table modules
`default_nettype none

package tkm_pkg;

    typedef enum logic [2:0] {
        ACT_CLEAR     = 3'd0,
        ACT_INSERT    = 3'd1,
        ACT_READ      = 3'd2,
        ACT_FIND_PAIR = 3'd3,
        ACT_FIND_TAG  = 3'd4,
        ACT_SIZE      = 3'd5
    } action_t;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;
    localparam logic [1:0] ST_RANGE     = 2'd3;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } state_t;

    // control part of a search request walking the chain
    typedef struct packed {
        logic    valid;
        logic    hit;
        action_t act;
    } tok_ctl_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [3:0]  ptype;
        logic [15:0] sid;
        logic [5:0]  pos;
    } key_t;

    typedef struct packed {
        logic [31:0] tag;
        logic [3:0]  ptype;
        logic [15:0] sid;
    } entry_t;

endpackage

`default_nettype wire

### rtl/tkm_cell.sv
// one table entry with its compare stage in the search chain
`default_nettype none

module tkm_cell #(
    parameter int INDEX = 0,
    parameter int IDX_W = 6,
    parameter int CNT_W = 7,
    parameter int TAG_W = 32
) (
    input  wire                      clk,
    input  wire                      rst_n,
    input  wire                      wr_en,
    input  tkm_pkg::entry_t          wr_ent,
    input  wire  [CNT_W-1:0]         fill,
    input  tkm_pkg::tok_ctl_t        ctl_in,
    input  tkm_pkg::key_t            key_in,
    input  wire  [IDX_W-1:0]         hit_idx_in,
    input  tkm_pkg::entry_t          hit_ent_in,
    output tkm_pkg::tok_ctl_t        ctl_out,
    output tkm_pkg::key_t            key_out,
    output logic [IDX_W-1:0]         hit_idx_out,
    output tkm_pkg::entry_t          hit_ent_out
);

    logic [TAG_W-1:0]  tag_reg;
    logic [3:0]        type_reg;
    logic [15:0]       id_reg;

    tkm_pkg::tok_ctl_t ctl_reg;
    tkm_pkg::tok_ctl_t ctl_next;
    tkm_pkg::key_t     key_reg;
    logic [IDX_W-1:0]  idx_reg;
    logic [IDX_W-1:0]  idx_next;
    tkm_pkg::entry_t   ent_reg;
    tkm_pkg::entry_t   ent_next;

    logic filled;
    logic hit_here;
    logic take;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            tag_reg  <= wr_ent.tag[TAG_W-1:0];
            type_reg <= wr_ent.ptype;
            id_reg   <= wr_ent.sid;
        end
    end

    always_comb
    begin
        filled = (CNT_W'(INDEX) < fill);
        case (ctl_in.act)
            tkm_pkg::ACT_READ:
                hit_here = (int'(key_in.pos) == INDEX);
            tkm_pkg::ACT_FIND_PAIR:
                hit_here = (type_reg == key_in.ptype) && (id_reg == key_in.sid);
            tkm_pkg::ACT_FIND_TAG:
                hit_here = (tag_reg == key_in.tag[TAG_W-1:0]);
            default:
                hit_here = 1'b0;
        endcase
        // first filled match wins, later cells only pass it on
        take = ctl_in.valid && !ctl_in.hit && filled && hit_here;

        ctl_next = ctl_in;
        idx_next = hit_idx_in;
        ent_next = hit_ent_in;
        if (take)
        begin
            ctl_next.hit = 1'b1;
            idx_next     = IDX_W'(INDEX);
            ent_next     = '{tag: 32'(tag_reg), ptype: type_reg, sid: id_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg <= key_in;
        idx_reg <= idx_next;
        ent_reg <= ent_next;
    end

    assign ctl_out     = ctl_reg;
    assign key_out     = key_reg;
    assign hit_idx_out = idx_reg;
    assign hit_ent_out = ent_reg;

endmodule

`default_nettype wire

### rtl/two_key_mapping_table.sv
// append-only mapping table with search by tag or by type and id
//
// Clear, insert, size and unused action codes complete without a walk: the
// result strobe (done) comes in the cycle after start, and busy stays low.
// Read and the two searches send a request down a chain of CAPACITY cells,
// one cell per cycle, each cell holding one entry and its comparators:
// busy is high while the request walks, and done pulses in the same cycle
// that busy falls. Results are presented for exactly one cycle while done
// is high and must be captured then.
`default_nettype none
`include "two_key_mapping_table_assert.svh"

module two_key_mapping_table #(
    parameter int CAPACITY = 64,
    parameter int TAG_BITS = 32
) (
    input  wire          clk,
    input  wire          rst_n,
    input  wire          start,
    input  wire  [2:0]   action,
    input  wire  [31:0]  tag,
    input  wire  [3:0]   point_kind,
    input  wire  [15:0]  point_num,
    input  wire  [5:0]   position,
    output logic         busy,
    output logic         done,
    output logic [1:0]   status,
    output logic [5:0]   entry_index,
    output logic [31:0]  found_tag,
    output logic [3:0]   found_type,
    output logic [15:0]  found_id,
    output logic [6:0]   fill_level
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int TAG_W = (TAG_BITS < 32) ? TAG_BITS : 32;

    tkm_pkg::state_t   state_reg;
    tkm_pkg::state_t   state_next;
    logic [CNT_W-1:0]  fill_reg;
    logic [CNT_W-1:0]  fill_next;
    tkm_pkg::tok_ctl_t launch_ctl_reg;
    tkm_pkg::tok_ctl_t launch_ctl_next;
    tkm_pkg::key_t     launch_key_reg;
    tkm_pkg::key_t     launch_key_next;

    logic              done_reg;
    logic              done_next;
    logic [1:0]        status_reg;
    logic [1:0]        status_next;
    logic [5:0]        index_reg;
    logic [5:0]        index_next;
    tkm_pkg::entry_t   res_reg;
    tkm_pkg::entry_t   res_next;

    logic              accept;
    logic              ins_we;
    tkm_pkg::action_t  act;
    tkm_pkg::entry_t   wr_ent;

    tkm_pkg::tok_ctl_t ctl_bus [0:CAPACITY];
    tkm_pkg::key_t     key_bus [0:CAPACITY];
    logic [IDX_W-1:0]  idx_bus [0:CAPACITY];
    tkm_pkg::entry_t   ent_bus [0:CAPACITY];

    assign busy   = (state_reg == tkm_pkg::S_WALK);
    assign accept = start && !busy;
    assign act    = tkm_pkg::action_t'(action);
    assign wr_ent = '{tag: tag, ptype: point_kind, sid: point_num};

    assign ctl_bus[0] = launch_ctl_reg;
    assign key_bus[0] = launch_key_reg;
    assign idx_bus[0] = '0;
    assign ent_bus[0] = '0;

    for (genvar k = 0; k < CAPACITY; k++)
    begin : g_cell
        tkm_cell #(
            .INDEX (k),
            .IDX_W (IDX_W),
            .CNT_W (CNT_W),
            .TAG_W (TAG_W)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .wr_en       (ins_we && (fill_reg == CNT_W'(k))),
            .wr_ent      (wr_ent),
            .fill        (fill_reg),
            .ctl_in      (ctl_bus[k]),
            .key_in      (key_bus[k]),
            .hit_idx_in  (idx_bus[k]),
            .hit_ent_in  (ent_bus[k]),
            .ctl_out     (ctl_bus[k+1]),
            .key_out     (key_bus[k+1]),
            .hit_idx_out (idx_bus[k+1]),
            .hit_ent_out (ent_bus[k+1])
        );
    end

    always_comb
    begin
        state_next      = state_reg;
        fill_next       = fill_reg;
        launch_ctl_next = '0;
        launch_key_next = '{tag: tag, ptype: point_kind, sid: point_num, pos: position};
        done_next       = 1'b0;
        status_next     = tkm_pkg::ST_OK;
        index_next      = '0;
        res_next        = '0;
        ins_we          = 1'b0;

        unique case (state_reg)
            tkm_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    done_next = 1'b1;
                    unique case (act)
                        tkm_pkg::ACT_CLEAR:
                        begin
                            fill_next = '0;
                        end
                        tkm_pkg::ACT_INSERT:
                        begin
                            if (fill_reg >= CNT_W'(CAPACITY))
                            begin
                                status_next = tkm_pkg::ST_FULL;
                            end
                            else
                            begin
                                ins_we    = 1'b1;
                                fill_next = fill_reg + CNT_W'(1);
                            end
                        end
                        tkm_pkg::ACT_READ,
                        tkm_pkg::ACT_FIND_PAIR,
                        tkm_pkg::ACT_FIND_TAG:
                        begin
                            done_next           = 1'b0;
                            launch_ctl_next.valid = 1'b1;
                            launch_ctl_next.act   = act;
                            state_next          = tkm_pkg::S_WALK;
                        end
                        default:
                        begin
                        end
                    endcase
                end
            end
            tkm_pkg::S_WALK:
            begin
                if (ctl_bus[CAPACITY].valid)
                begin
                    done_next  = 1'b1;
                    state_next = tkm_pkg::S_IDLE;
                    if (ctl_bus[CAPACITY].hit)
                    begin
                        index_next = 6'(idx_bus[CAPACITY]);
                        res_next   = ent_bus[CAPACITY];
                    end
                    else if (ctl_bus[CAPACITY].act == tkm_pkg::ACT_READ)
                    begin
                        status_next = tkm_pkg::ST_RANGE;
                    end
                    else
                    begin
                        status_next = tkm_pkg::ST_NOT_FOUND;
                    end
                end
            end
            default:
            begin
                state_next = tkm_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= tkm_pkg::S_IDLE;
            fill_reg       <= '0;
            launch_ctl_reg <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            fill_reg       <= fill_next;
            launch_ctl_reg <= launch_ctl_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        launch_key_reg <= launch_key_next;
        status_reg     <= status_next;
        index_reg      <= index_next;
        res_reg        <= res_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign entry_index = index_reg;
    assign found_tag   = res_reg.tag;
    assign found_type  = res_reg.ptype;
    assign found_id    = res_reg.sid;
    assign fill_level  = 7'(fill_reg);

    `TKM_ASSERT_SAME(a_done_idle, done_reg, state_reg == tkm_pkg::S_IDLE, "result while walking")
    `TKM_ASSERT_SAME(a_walk_out, ctl_bus[CAPACITY].valid, state_reg == tkm_pkg::S_WALK, "stray request at chain end")
    `TKM_ASSERT_SAME(a_fill_cap, 1'b1, fill_reg <= CNT_W'(CAPACITY), "fill count past capacity")
    `TKM_ASSERT_NEXT(a_full_hold, accept && act == tkm_pkg::ACT_INSERT && fill_reg == CNT_W'(CAPACITY), fill_reg == CNT_W'(CAPACITY) && status_reg == tkm_pkg::ST_FULL, "insert into full table changed it")

endmodule

`default_nettype wire
